/* sv/jnic_pkg.sv */
// Shared types and constants for the JSON number integer check.
package jnic_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_E_LO  = 8'h65;
   localparam logic [7:0] CH_E_UP  = 8'h45;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef enum logic [2:0] {
      CLS_ZERO,
      CLS_DIGIT,
      CLS_MINUS,
      CLS_PLUS,
      CLS_DOT,
      CLS_EXP,
      CLS_OTHER
   } char_class_type;

   typedef struct packed {
      char_class_type cls;
      logic [3:0]     digit;
      logic           last;
   } char_entry_type;

endpackage

/* sv/jnic_if.sv */
// Handshake channels for characters in and results out.
interface jnic_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       last_char;

   modport source (output valid, output char_byte, output last_char, input ready);
   modport sink   (input valid, input char_byte, input last_char, output ready);
endinterface

interface jnic_rsp_if;
   logic valid;
   logic ready;
   logic is_integer;
   logic malformed;
   logic too_long;

   modport source (output valid, output is_integer, output malformed, output too_long,
                   input ready);
   modport sink   (input valid, input is_integer, input malformed, input too_long,
                   output ready);
endinterface

/* sv/jnic_front.sv */
// Front end: accepts character beats and sorts them into grammar classes.
module jnic_front
   import jnic_pkg::*;
(
   jnic_req_if.sink       req_if,
   input  logic           full,
   output logic           push,
   output char_entry_type entry
);

   logic [7:0] ch;

   assign ch            = req_if.char_byte;
   assign req_if.ready  = !full;
   assign push          = req_if.valid && !full;

   always_comb begin
      entry.last  = req_if.last_char;
      entry.digit = 4'(ch - CH_ZERO);
      priority if (ch == CH_ZERO) begin
         entry.cls = CLS_ZERO;
      end else if (ch > CH_ZERO && ch <= CH_NINE) begin
         entry.cls = CLS_DIGIT;
      end else if (ch == CH_MINUS) begin
         entry.cls = CLS_MINUS;
      end else if (ch == CH_PLUS) begin
         entry.cls = CLS_PLUS;
      end else if (ch == CH_DOT) begin
         entry.cls = CLS_DOT;
      end else if (ch == CH_E_LO || ch == CH_E_UP) begin
         entry.cls = CLS_EXP;
      end else begin
         entry.cls = CLS_OTHER;
      end
   end

endmodule

/* sv/jnic_queue.sv */
// Short queue of classified characters between front and back.
module jnic_queue
   import jnic_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  char_entry_type push_entry,
   output logic           full,
   input  logic           pop,
   output logic           head_valid,
   output char_entry_type head_entry
);

   char_entry_type        mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;

   assign full       = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* sv/jnic_back.sv */
// Back end: number grammar tracking, counters and the result register.
module jnic_back
   import jnic_pkg::*;
#(
   parameter int MAX_LEN = 4096
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           head_valid,
   input  char_entry_type head_entry,
   output logic           pop,
   jnic_rsp_if.source     rsp_if
);

   localparam int CW = $clog2(MAX_LEN + 2);
   localparam logic [CW-1:0]   MAX_W  = CW'(MAX_LEN);
   localparam logic [CW+3:0]   MAX_X  = (CW+4)'(MAX_LEN);

   typedef enum logic [2:0] {
      PH_START,
      PH_INT,
      PH_FRAC,
      PH_EXP_SIGN,
      PH_EXP_DIGIT
   } phase_type;

   phase_type     phase_ff, phase_in;
   logic          int_seen_ff, int_seen_in;
   logic          exp_neg_ff, exp_neg_in;
   logic          all_zero_ff, all_zero_in;
   logic          bad_ff, bad_in;
   logic [CW-1:0] tz_ff, tz_in;
   logic [CW-1:0] frac_ff, frac_in;
   logic [CW-1:0] exp_ff, exp_in;
   logic [CW-1:0] len_ff, len_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          is_int_ff, is_int_in;
   logic          malformed_ff, malformed_in;
   logic          too_long_ff, too_long_in;

   logic          out_free, take_last;
   logic          is_dig, coef_upd, exp_upd;
   logic [CW+3:0] exp_ext;
   logic          integral, bad_res, long_res;

   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign pop       = head_valid && (!head_entry.last || out_free);
   assign take_last = pop && head_entry.last;
   assign is_dig    = (head_entry.cls == CLS_ZERO) || (head_entry.cls == CLS_DIGIT);

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.is_integer = is_int_ff;
   assign rsp_if.malformed  = malformed_ff;
   assign rsp_if.too_long   = too_long_ff;

   always_comb begin
      phase_in    = phase_ff;
      int_seen_in = int_seen_ff;
      exp_neg_in  = exp_neg_ff;
      all_zero_in = all_zero_ff;
      bad_in      = bad_ff;
      tz_in       = tz_ff;
      frac_in     = frac_ff;
      exp_in      = exp_ff;
      coef_upd    = 1'b0;
      exp_upd     = 1'b0;
      exp_ext     = '0;
      len_in      = (len_ff <= MAX_W) ? len_ff + 1'b1 : len_ff;

      if (!bad_ff) begin
         unique case (phase_ff)
            PH_START, PH_INT: begin
               priority if (phase_ff == PH_START && head_entry.cls == CLS_MINUS) begin
                  phase_in = PH_INT;
               end else if (is_dig) begin
                  int_seen_in = 1'b1;
                  coef_upd    = 1'b1;
                  phase_in    = PH_INT;
               end else if (head_entry.cls == CLS_DOT) begin
                  phase_in = PH_FRAC;
               end else if (head_entry.cls == CLS_EXP) begin
                  phase_in = PH_EXP_SIGN;
               end else begin
                  bad_in = 1'b1;
               end
            end
            PH_FRAC: begin
               priority if (is_dig) begin
                  frac_in  = (frac_ff < MAX_W) ? frac_ff + 1'b1 : MAX_W;
                  coef_upd = 1'b1;
               end else if (head_entry.cls == CLS_EXP) begin
                  phase_in = PH_EXP_SIGN;
               end else begin
                  bad_in = 1'b1;
               end
            end
            PH_EXP_SIGN: begin
               priority if (head_entry.cls == CLS_PLUS || head_entry.cls == CLS_MINUS) begin
                  exp_neg_in = (head_entry.cls == CLS_MINUS);
                  phase_in   = PH_EXP_DIGIT;
               end else if (is_dig) begin
                  exp_upd  = 1'b1;
                  phase_in = PH_EXP_DIGIT;
               end else begin
                  bad_in = 1'b1;
               end
            end
            PH_EXP_DIGIT: begin
               if (is_dig) begin
                  exp_upd = 1'b1;
               end else begin
                  bad_in = 1'b1;
               end
            end
            default: begin
               bad_in = 1'b1;
            end
         endcase
      end

      if (coef_upd) begin
         if (head_entry.cls == CLS_ZERO) begin
            tz_in = (tz_ff < MAX_W) ? tz_ff + 1'b1 : MAX_W;
         end else begin
            all_zero_in = 1'b0;
            tz_in       = '0;
         end
      end

      // exponent times ten plus digit, saturating at the length limit
      if (exp_upd) begin
         if (exp_ff >= MAX_W) begin
            exp_in = MAX_W;
         end else begin
            exp_ext = ((CW+4)'(exp_ff) << 3) + ((CW+4)'(exp_ff) << 1)
                      + (CW+4)'(head_entry.digit);
            exp_in  = (exp_ext > MAX_X) ? MAX_W : exp_ext[CW-1:0];
         end
      end
   end

   always_comb begin
      if (all_zero_in) begin
         integral = 1'b1;
      end else if (!exp_neg_in) begin
         integral = (exp_in >= frac_in) || ((frac_in - exp_in) <= tz_in);
      end else begin
         integral = (exp_in <= tz_in) && (frac_in <= (tz_in - exp_in));
      end
      long_res     = (len_in > MAX_W);
      bad_res      = bad_in || !int_seen_in;
      is_int_in    = !long_res && !bad_res && integral;
      malformed_in = !long_res && bad_res;
      too_long_in  = long_res;
      rsp_valid_in = take_last || (rsp_valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         int_seen_ff  <= 1'b0;
         exp_neg_ff   <= 1'b0;
         all_zero_ff  <= 1'b1;
         bad_ff       <= 1'b0;
         tz_ff        <= '0;
         frac_ff      <= '0;
         exp_ff       <= '0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         is_int_ff    <= 1'b0;
         malformed_ff <= 1'b0;
         too_long_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take_last) begin
            phase_ff     <= PH_START;
            int_seen_ff  <= 1'b0;
            exp_neg_ff   <= 1'b0;
            all_zero_ff  <= 1'b1;
            bad_ff       <= 1'b0;
            tz_ff        <= '0;
            frac_ff      <= '0;
            exp_ff       <= '0;
            len_ff       <= '0;
            is_int_ff    <= is_int_in;
            malformed_ff <= malformed_in;
            too_long_ff  <= too_long_in;
         end else if (pop) begin
            phase_ff    <= phase_in;
            int_seen_ff <= int_seen_in;
            exp_neg_ff  <= exp_neg_in;
            all_zero_ff <= all_zero_in;
            bad_ff      <= bad_in;
            tz_ff       <= tz_in;
            frac_ff     <= frac_in;
            exp_ff      <= exp_in;
            len_ff      <= len_in;
         end
      end
   end

   a_state_clear: assert property (@(posedge clock) disable iff (reset)
      take_last |=> (phase_ff == PH_START && len_ff == '0 && all_zero_ff && !bad_ff))
      else $error("parser state not cleared after last beat");

   a_exp_sat: assert property (@(posedge clock) disable iff (reset)
      exp_ff <= MAX_W)
      else $error("exponent above saturation limit");

   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      (tz_ff <= len_ff) && (frac_ff <= len_ff))
      else $error("digit count exceeds character count");

   a_result_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(is_int_ff && (malformed_ff || too_long_ff))
                       && !(malformed_ff && too_long_ff))
      else $error("inconsistent result flags");

endmodule

/* sv/json_number_integer_check_top.sv */
// Top level of the JSON number integer check.
// Takes a JSON number text one character beat per cycle, last_char set on the
// final character, and returns one result beat per text: is_integer, malformed
// and too_long (more than MAX_LEN characters). A character can be accepted every
// cycle while the queue is not full; the back end updates the parser state and
// counters once per character. A result is presented from the cycle after the
// back end takes the last character. A four-entry queue between the classifying
// front end and the back end, and the result register, absorb stalls on either
// side; a held result stops the back end only at a text's last character.
module json_number_integer_check_top
   import jnic_pkg::*;
#(
   parameter int MAX_LEN = 4096
) (
   input  logic        clock,
   input  logic        reset,
   jnic_req_if.sink    req_if,
   jnic_rsp_if.source  rsp_if
);

   logic           push, full, pop, head_valid;
   char_entry_type push_entry, head_entry;

   jnic_front u_front (
      .req_if (req_if),
      .full   (full),
      .push   (push),
      .entry  (push_entry)
   );

   jnic_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   jnic_back #(
      .MAX_LEN (MAX_LEN)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_if     (rsp_if)
   );

endmodule
